>>> hdl/psv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psv_pkg
// Shared types and constants for the plot stream validator: opcode classes,
// result status codes and the character codes the parser looks for.
// ----------------------------------------------------------------------------
package psv_pkg;

  // Width of the fixed payload counter; the longest record is 48 bytes.
  localparam int unsigned LEN_W = 6;

  // Character codes used by the opcode range check and the string end.
  localparam logic [7:0] CHAR_FIRST   = 8'h41;  // 'A'
  localparam logic [7:0] CHAR_LAST    = 8'h7A;  // 'z'
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;  // '\n'

  // Opcode classes.
  typedef enum logic [1:0] {
    KIND_BAD    = 2'd0,
    KIND_FIXED  = 2'd1,
    KIND_STRING = 2'd2
  } kind_e;

  // Result status codes.
  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_ERROR   = 2'd1,
    STAT_VALID   = 2'd2,
    STAT_INVALID = 2'd3
  } status_e;

  // Class of one opcode and the length of its fixed payload.
  typedef struct packed {
    kind_e            kind;
    logic [LEN_W-1:0] len;
  } opclass_t;

endpackage
`default_nettype wire

>>> hdl/psv_classify.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psv_classify
// Opcode decoder: maps one stream byte to its class and, for fixed records,
// the number of payload bytes that follow it.
// ----------------------------------------------------------------------------
module psv_classify #(
  parameter int unsigned DOUBLE_BYTES = 8
) (
  input  wire logic [7:0]       opcode_i,
  output psv_pkg::opclass_t     class_o
);

  localparam logic [psv_pkg::LEN_W-1:0] DblLen = psv_pkg::LEN_W'(DOUBLE_BYTES);

  logic [2:0]                 shorts;
  logic [2:0]                 doubles;
  psv_pkg::kind_e             kind;
  logic [psv_pkg::LEN_W-1:0]  fixed_len;

  // Decode the opcode into a class and its fixed payload length in bytes.
  always_comb begin
    shorts    = 3'd0;
    doubles   = 3'd0;
    kind      = psv_pkg::KIND_FIXED;
    fixed_len = '0;
    if (opcode_i < psv_pkg::CHAR_FIRST || opcode_i > psv_pkg::CHAR_LAST) begin
      kind = psv_pkg::KIND_BAD;
    end else begin
      unique case (opcode_i) inside
        "C":           fixed_len = psv_pkg::LEN_W'(3);
        "F", "e":      fixed_len = '0;
        "f", "t":      kind = psv_pkg::KIND_STRING;
        "m", "n", "p":      shorts = 3'd2;
        "M", "N", "P", "c": shorts = 3'd3;
        "l", "s":           shorts = 3'd4;
        "L", "S", "a":      shorts = 3'd6;
        "o", "q", "x":      doubles = 3'd2;
        "O", "Q", "X", "i": doubles = 3'd3;
        "v", "w":           doubles = 3'd4;
        "V", "W", "r":      doubles = 3'd6;
        default:       kind = psv_pkg::KIND_BAD;
      endcase
      if (shorts != 3'd0 || doubles != 3'd0) begin
        fixed_len = psv_pkg::LEN_W'({shorts, 1'b0})
                  + psv_pkg::LEN_W'(psv_pkg::LEN_W'(doubles) * DblLen);
      end
    end
  end

  assign class_o.kind = kind;
  assign class_o.len  = (kind == psv_pkg::KIND_FIXED) ? fixed_len : '0;

endmodule
`default_nettype wire

>>> hdl/plot_stream_validator_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plot_stream_validator_unit
// Byte-at-a-time checker for a binary 3-D plot command stream.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries one item per stream byte (command_i = 0) or an
//   end-of-stream marker (command_i = 1). Every accepted item yields exactly
//   one result item on the output channel: a running status with the count
//   of fixed payload bytes still expected, or, for the end marker, the
//   verdict for the whole stream, after which the parser state is cleared.
//   Each result is held in the result register, or in the skid register
//   while the receiver stalls. Throughput is one item per cycle while the
//   skid register is empty, set by the single parser state update (opcode
//   decode plus counter step) between the state and result registers.
//   A receiver stall holds the result register; one more item is taken into
//   a skid register, and only while that register is full does in_stall_o
//   rise, so in_stall_o comes straight from a flop.
//   Reset clears the parser state and empties both result registers; the
//   block takes items in the first cycle after reset.
// ----------------------------------------------------------------------------
module plot_stream_validator_unit #(
  parameter int unsigned DOUBLE_BYTES = 8
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // Input channel
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic                        command_i,
  input  wire logic [7:0]                  data_byte_i,
  // Output channel
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [1:0]                       status_o,
  output logic [psv_pkg::LEN_W-1:0]        bytes_pending_o
);

  localparam int unsigned LW = psv_pkg::LEN_W;

  // Parser state.
  logic [LW-1:0]      payload_left_q, payload_left_d;
  logic               in_string_q, in_string_d;
  logic               failed_q, failed_d;

  // Result and skid registers.
  logic               out_valid_q;
  logic [1:0]         out_status_q;
  logic [LW-1:0]      out_pending_q;
  logic               skid_valid_q;
  logic [1:0]         skid_status_q;
  logic [LW-1:0]      skid_pending_q;

  logic               accept;
  logic               out_ready;
  psv_pkg::opclass_t  op_class;
  psv_pkg::status_e   res_status;
  logic [LW-1:0]      res_pending;

  assign in_stall_o = skid_valid_q;
  assign accept     = in_valid_i && !skid_valid_q;
  assign out_ready  = !out_valid_q || !out_stall_i;

  // Opcode decoder.
  psv_classify #(
    .DOUBLE_BYTES(DOUBLE_BYTES)
  ) u_classify (
    .opcode_i(data_byte_i),
    .class_o (op_class)
  );

  // Next parser state and the result for the incoming item.
  always_comb begin
    payload_left_d = payload_left_q;
    in_string_d    = in_string_q;
    failed_d       = failed_q;
    res_status     = psv_pkg::STAT_OK;
    res_pending    = '0;
    if (command_i) begin
      res_status     = (failed_q || payload_left_q != '0) ? psv_pkg::STAT_INVALID
                                                          : psv_pkg::STAT_VALID;
      payload_left_d = '0;
      in_string_d    = 1'b0;
      failed_d       = 1'b0;
    end else begin
      if (!failed_q) begin
        if (payload_left_q != '0) begin
          payload_left_d = payload_left_q - LW'(1);
        end else if (in_string_q) begin
          if (data_byte_i == psv_pkg::CHAR_NEWLINE) begin
            in_string_d = 1'b0;
          end
        end else begin
          unique case (op_class.kind)
            psv_pkg::KIND_FIXED:  payload_left_d = op_class.len;
            psv_pkg::KIND_STRING: in_string_d    = 1'b1;
            default: begin
              failed_d       = 1'b1;
              payload_left_d = '0;
              in_string_d    = 1'b0;
            end
          endcase
        end
      end
      res_status  = failed_d ? psv_pkg::STAT_ERROR : psv_pkg::STAT_OK;
      res_pending = payload_left_d;
    end
  end

  // Parser state registers, updated on every accepted item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      payload_left_q <= '0;
      in_string_q    <= 1'b0;
      failed_q       <= 1'b0;
    end else if (accept) begin
      payload_left_q <= payload_left_d;
      in_string_q    <= in_string_d;
      failed_q       <= failed_d;
    end
  end

  // Result register with a one-entry skid behind it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_ready) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q  <= accept;
      end
    end else if (accept) begin
      skid_valid_q <= 1'b1;
    end
  end

  // Result payloads; no reset needed.
  always_ff @(posedge clk_i) begin
    if (out_ready) begin
      if (skid_valid_q) begin
        out_status_q  <= skid_status_q;
        out_pending_q <= skid_pending_q;
      end else if (accept) begin
        out_status_q  <= res_status;
        out_pending_q <= res_pending;
      end
    end else if (accept) begin
      skid_status_q  <= res_status;
      skid_pending_q <= res_pending;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign bytes_pending_o = out_pending_q;

  // An error clears any record in progress.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    failed_q |-> (payload_left_q == '0 && !in_string_q))
    else $error("failed state with a record still open");

  // A fixed payload and a string are never open at the same time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (payload_left_q != '0) |-> !in_string_q)
    else $error("fixed payload and string open together");

  // The skid register only fills behind a full result register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid register full while result register is empty");

  // An accepted end marker leaves the parser cleared.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && command_i) |=> (payload_left_q == '0 && !in_string_q && !failed_q))
    else $error("parser state not cleared after end of stream");

endmodule
`default_nettype wire
